FILE: design/edd_pkg.sv
package edd_pkg;

  // Request opcodes
  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_CAND   = 2'd2,
    OP_FINISH = 2'd3
  } op_t;

  // Sequencer states
  typedef enum logic {
    S_IDLE  = 1'b0,
    S_SWEEP = 1'b1
  } state_t;

  localparam int DIST_W = 7;
  localparam int DIST_MAX = 127;

  typedef struct packed {
    op_t        op;
    logic [7:0] ch;
  } req_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              overflow;
  } rsp_t;

endpackage

FILE: design/edd_ram.sv
module edd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/edd_cell.sv
module edd_cell #(
  parameter int COST_W = 7
) (
  input  logic [COST_W-1:0] diag,
  input  logic [COST_W-1:0] up,
  input  logic [COST_W-1:0] left_cost,
  input  logic              match,
  output logic [COST_W-1:0] best
);

  logic [COST_W-1:0] min_a;
  logic [COST_W-1:0] min_b;

  // match keeps the diagonal, otherwise cheapest neighbour plus one
  always_comb begin
    min_a = (up < diag) ? up : diag;
    min_b = (left_cost < min_a) ? left_cost : min_a;
    if (match) begin
      best = diag;
    end else begin
      best = min_b + 1'b1;
    end
  end

endmodule

FILE: design/edit_distance_engine.sv
// Levenshtein edit distance between a stored pattern (op 1 appends a character)
// and a streamed candidate (op 2 per character); op 3 returns the distance and the
// sticky overflow flag and rewinds the candidate, op 0 clears everything. With an
// empty pattern a candidate character only counts the candidate length; otherwise it
// starts a sweep: the cost row lives in a synchronous memory and the sweep reads,
// updates and writes back one cell per cycle, so the single row-memory port pair
// sets the rate; requests stall until the sweep ends. No clearing pass follows
// reset: a rewound row is implied by a zero candidate length. A finished result
// sits in an output register, so further requests outside a sweep are taken while
// it waits; only a second finish stalls until the first is taken.
module edit_distance_engine #(
  parameter int MAX_LEN = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  edd_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output edd_pkg::rsp_t rsp
);

  import edd_pkg::*;

  localparam int IDX_W = $clog2(MAX_LEN);
  localparam int LEN_W = $clog2(MAX_LEN + 1);
  localparam int COST_W = LEN_W;
  localparam int SAT_W = (LEN_W > DIST_W) ? LEN_W : DIST_W;
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_LEN);

  state_t             state;
  state_t             state_next;
  logic [LEN_W-1:0]   plen;
  logic [LEN_W-1:0]   clen;
  logic               dropped;
  logic [IDX_W-1:0]   wr_idx;
  logic [7:0]         cur_ch;
  logic               first;
  logic [COST_W-1:0]  diag;
  logic [COST_W-1:0]  left_cost;
  logic [COST_W-1:0]  final_cost;
  rsp_t               rsp_q;

  logic               acc;
  logic               pat_we;
  logic               row_we;
  logic [IDX_W-1:0]   rd_addr;
  logic [7:0]         pat_rdata;
  logic [COST_W-1:0]  row_rdata;
  logic [COST_W-1:0]  up;
  logic [COST_W-1:0]  best;
  logic               last_cell;
  logic [LEN_W-1:0]   dist_raw;
  logic [SAT_W-1:0]   dist_ext;
  logic [DIST_W-1:0]  dist_sat;

  // handshake: busy during a sweep, a second finish waits for the output register
  assign req_stall = (state != S_IDLE) || (rsp_valid && rsp_stall && req.op == OP_FINISH);
  assign acc = req_valid && !req_stall;
  assign rsp = rsp_q;

  // pattern store and cost row, both indexed by pattern position minus one
  edd_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_pat (
    .clk   (clk),
    .we    (pat_we),
    .waddr (plen[IDX_W-1:0]),
    .wdata (req.ch),
    .raddr (rd_addr),
    .rdata (pat_rdata)
  );

  edd_ram #(.WIDTH(COST_W), .DEPTH(MAX_LEN)) u_row (
    .clk   (clk),
    .we    (row_we),
    .waddr (wr_idx),
    .wdata (best),
    .raddr (rd_addr),
    .rdata (row_rdata)
  );

  // first row after a rewind is implicit: cost_row[j] = j
  assign up = first ? (COST_W'(wr_idx) + 1'b1) : row_rdata;

  edd_cell #(.COST_W(COST_W)) u_cell (
    .diag      (diag),
    .up        (up),
    .left_cost (left_cost),
    .match     (pat_rdata == cur_ch),
    .best      (best)
  );

  assign last_cell = (LEN_W'(wr_idx) + 1'b1) == plen;

  // distance: empty pattern gives the candidate length, empty candidate the pattern length
  always_comb begin
    if (plen == '0) begin
      dist_raw = clen;
    end else if (clen == '0) begin
      dist_raw = plen;
    end else begin
      dist_raw = final_cost;
    end
    dist_ext = SAT_W'(dist_raw);
    if (dist_ext > SAT_W'(DIST_MAX)) begin
      dist_sat = DIST_W'(DIST_MAX);
    end else begin
      dist_sat = dist_ext[DIST_W-1:0];
    end
  end

  // sequencer: next state and memory control
  always_comb begin
    state_next = state;
    pat_we = 1'b0;
    row_we = 1'b0;
    rd_addr = '0;
    unique case (state)
      S_IDLE: begin
        pat_we = acc && req.op == OP_APPEND && plen < LEN_MAX;
        if (acc && req.op == OP_CAND && clen < LEN_MAX && plen != '0) begin
          state_next = S_SWEEP;
        end
      end
      S_SWEEP: begin
        row_we = 1'b1;
        rd_addr = wr_idx + 1'b1;
        if (last_cell) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      plen <= '0;
      clen <= '0;
      dropped <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      // a new finish refills the output register as the old result leaves
      if (acc && req.op == OP_FINISH) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (acc) begin
        unique case (req.op)
          OP_CLEAR: begin
            plen <= '0;
            clen <= '0;
            dropped <= 1'b0;
          end
          OP_APPEND: begin
            if (plen < LEN_MAX) begin
              plen <= plen + 1'b1;
            end else begin
              dropped <= 1'b1;
            end
            clen <= '0;
          end
          OP_CAND: begin
            if (clen >= LEN_MAX) begin
              dropped <= 1'b1;
            end else if (plen == '0) begin
              clen <= clen + 1'b1;
            end
          end
          OP_FINISH: begin
            clen <= '0;
          end
          default: begin
          end
        endcase
      end
      if (state == S_SWEEP && last_cell) begin
        clen <= clen + 1'b1;
      end
    end
  end

  // sweep datapath and result register
  always_ff @(posedge clk) begin
    if (acc && req.op == OP_CAND) begin
      cur_ch <= req.ch;
      diag <= clen;
      left_cost <= clen + 1'b1;
      first <= (clen == '0);
      wr_idx <= '0;
    end
    if (acc && req.op == OP_FINISH) begin
      rsp_q.distance <= dist_sat;
      rsp_q.overflow <= dropped;
    end
    if (state == S_SWEEP) begin
      left_cost <= best;
      diag <= up;
      wr_idx <= wr_idx + 1'b1;
      if (last_cell) begin
        final_cost <= best;
      end
    end
  end

endmodule

FILE: design/edd_checker.sv
module edd_checker #(
  parameter int MAX_LEN = 64
) (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_stall,
  input edd_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input edd_pkg::rsp_t rsp
);

  import edd_pkg::*;

  logic req_acc;
  assign req_acc = req_valid && !req_stall;

  // a stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("result changed or vanished while stalled");

  // every accepted finish shows a result next cycle
  a_finish_rsp: assert property (@(posedge clk) disable iff (rst)
    req_acc && req.op == OP_FINISH |=> rsp_valid)
    else $error("finish request gave no result");

  // clear straight into finish gives a clean zero
  a_clear_zero: assert property (@(posedge clk) disable iff (rst)
    req_acc && req.op == OP_CLEAR ##1 req_acc && req.op == OP_FINISH
    |=> rsp.distance == '0 && !rsp.overflow)
    else $error("distance after clear is not zero");

  // distance bounded by the string store length
  a_dist_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.distance <= MAX_LEN)
    else $error("distance beyond maximum length");

endmodule

bind edit_distance_engine edd_checker #(.MAX_LEN(MAX_LEN)) u_edd_checker (.*);
